// File: hw/rtl/bsoc_pkg.sv
package bsoc_pkg;

    // default charge precision (fraction bits of the internal charge)
    localparam int FRAC_BITS_DEF = 24;

    // field widths
    localparam int CUR_W      = 20;
    localparam int SUM_W      = 21;
    localparam int MAG_W      = 21;
    localparam int SCALE_W    = 40;
    localparam int SCALE_HALF = 20;
    localparam int RET_W      = 32;
    localparam int RET_HALF   = 16;
    localparam int DELTA_W    = 29;
    localparam int X_W        = 25;
    localparam int X_FRAC     = 24;
    localparam int ACC_W      = 28;
    localparam int VOLT_W     = 19;
    localparam int RES_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHARGE_SCALE = 2'd0,
        CFG_RETAIN       = 2'd1
    } cfg_reg_t;

    localparam logic [SCALE_W-1:0] SCALE_RST  = 40'd195000000;
    localparam logic [RET_W-1:0]   RETAIN_RST = 32'hFFFF_FFFF;

    // cubic fit coefficients, voltage in Q24 volt, resistance in 2^-32 ohm
    localparam logic signed [ACC_W-1:0] VOC_P1 = 28'sd29511123;
    localparam logic signed [ACC_W-1:0] VOC_P2 = 28'sd47798288;
    localparam logic signed [ACC_W-1:0] VOC_P3 = 28'sd39191577;
    localparam logic signed [ACC_W-1:0] VOC_P4 = 28'sd46070235;
    localparam logic signed [ACC_W-1:0] RS_P1  = 28'sd121676;
    localparam logic signed [ACC_W-1:0] RS_P2  = 28'sd584116;
    localparam logic signed [ACC_W-1:0] RS_P3  = 28'sd775671;
    localparam logic signed [ACC_W-1:0] RS_P4  = 28'sd581109;

    localparam logic signed [ACC_W-1:0] VOLT_SAT = 28'sd524287;
    localparam logic signed [ACC_W-1:0] RES_SAT  = 28'sd1048575;

    // horner steps: three for voltage, then three for resistance
    localparam int POLY_STEPS  = 6;
    localparam int VOLT_STEPS  = 3;
    localparam int STEP_W      = 3;

    typedef enum logic [2:0] {
        MS_SCALE_LO = 3'd0,
        MS_SCALE_HI = 3'd1,
        MS_RET_LO   = 3'd2,
        MS_RET_HI   = 3'd3,
        MS_POLY     = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic              load_in;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic              save_lo;
        logic              delta_en;
        logic              charge_en;
        logic              x_en;
        logic              poly_init;
        logic              poly_add;
        logic [STEP_W-1:0] step;
        logic              out_load;
    } dp_cmd_t;

    // coefficient added after the product of each horner step
    function automatic logic signed [ACC_W-1:0] poly_coef(input logic [STEP_W-1:0] step);
        case (step)
            3'd0:    return -VOC_P2;
            3'd1:    return VOC_P3;
            3'd2:    return VOC_P4;
            3'd3:    return RS_P2;
            3'd4:    return -RS_P3;
            3'd5:    return RS_P4;
            default: return '0;
        endcase
    endfunction

endpackage

// File: hw/rtl/battery_soc_coulomb_counter_core.sv
// Coulomb-counting state-of-charge estimator. Each input word is one battery
// current sample (1/16 mA, positive discharges, negative charges); the block
// integrates it with the previous sample by the trapezoid rule, scales the sum
// by charge_scale (config register 0, time step over capacity times 2^32),
// subtracts it from the stored charge, applies the self-discharge factor
// retain_factor (config register 1, Q0.32) and clamps the charge to 0..1.
// Every input word yields exactly one output word: the new charge in Q1.24,
// the open-circuit voltage (2^-16 V) and series resistance (2^-32 ohm) from
// cubic fits, and a depleted flag at or below one percent. After reset the
// charge is full and the previous sample is zero. A new word is accepted only
// once the previous one has been loaded into the output register (in_stall is
// high meanwhile), because the single shared multiplier carries all ten
// products of a word (two for the charge step, two for the retain factor,
// six for the two Horner evaluations) one after another. A finished result
// sits in an output register, so the next sample is taken while it waits.
// Config writes are always accepted (cfg_ready is tied high) and belong
// in idle periods; an index outside the register map is ignored.
module battery_soc_coulomb_counter_core
    import bsoc_pkg::*;
#(
    parameter int CHARGE_FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // sample input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [CUR_W-1:0] current_sample,
    // result output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [X_W-1:0]          charge_level,
    output logic [VOLT_W-1:0]       open_voltage,
    output logic [RES_W-1:0]        series_resistance,
    output logic                    depleted,
    // config write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    dp_cmd_t cmd;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencer: walks each word through the shared multiplier
    bsoc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // arithmetic, charge state, config registers and output word
    bsoc_datapath #(
        .FRAC_BITS (CHARGE_FRAC_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .current_sample    (current_sample),
        .charge_level      (charge_level),
        .open_voltage      (open_voltage),
        .series_resistance (series_resistance),
        .depleted          (depleted)
    );

endmodule

// File: hw/rtl/bsoc_ctrl.sv
module bsoc_ctrl
    import bsoc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DLO   = 11'b000_0000_0010,
        S_DHI   = 11'b000_0000_0100,
        S_DSUM  = 11'b000_0000_1000,
        S_RLO   = 11'b000_0001_0000,
        S_RHI   = 11'b000_0010_0000,
        S_RSUM  = 11'b000_0100_0000,
        S_XCALC = 11'b000_1000_0000,
        S_PMUL  = 11'b001_0000_0000,
        S_PADD  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(POLY_STEPS - 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DLO;
                end
            end
            S_DLO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_SCALE_LO;
                state_next  = S_DHI;
            end
            S_DHI:
            begin
                cmd.save_lo = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_SCALE_HI;
                state_next  = S_DSUM;
            end
            S_DSUM:
            begin
                cmd.delta_en = 1'b1;
                state_next   = S_RLO;
            end
            S_RLO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_RET_LO;
                state_next  = S_RHI;
            end
            S_RHI:
            begin
                cmd.save_lo = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_RET_HI;
                state_next  = S_RSUM;
            end
            S_RSUM:
            begin
                cmd.charge_en = 1'b1;
                state_next    = S_XCALC;
            end
            S_XCALC:
            begin
                cmd.x_en      = 1'b1;
                cmd.poly_init = 1'b1;
                step_next     = '0;
                state_next    = S_PMUL;
            end
            S_PMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_POLY;
                state_next  = S_PADD;
            end
            S_PADD:
            begin
                cmd.poly_add = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_PMUL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result register loaded while a word is still held");

    // horner counter stays within the six steps
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PADD) |-> (step_reg <= LAST_STEP))
        else $error("polynomial step out of range");

    // an accepted word starts the charge step in the next cycle
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DLO))
        else $error("accepted word did not start the sequence");

endmodule

// File: hw/rtl/bsoc_datapath.sv
module bsoc_datapath
    import bsoc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic signed [CUR_W-1:0] current_sample,
    output logic [X_W-1:0]          charge_level,
    output logic [VOLT_W-1:0]       open_voltage,
    output logic [RES_W-1:0]        series_resistance,
    output logic                    depleted
);

    localparam int CH_W   = FRAC_BITS + 1;
    localparam int NC_W   = ((CH_W > DELTA_W) ? CH_W : DELTA_W) + 2;
    localparam int A_W    = (NC_W > ACC_W) ? NC_W : ACC_W;
    localparam int B_W    = X_W + 1;
    localparam int P_W    = A_W + B_W;
    localparam int DPR_W  = MAG_W + SCALE_HALF;
    localparam int DSUM_W = DPR_W + SCALE_HALF + 1;
    localparam int RPR_W  = NC_W - 1 + RET_HALF;
    localparam int RSUM_W = NC_W + RET_W;
    localparam int DEP_W  = CH_W + 7;
    localparam int VQ_SH  = X_FRAC - (VOLT_W - 3);

    localparam logic [CH_W-1:0] FULL = CH_W'(1) << FRAC_BITS;

    // config and state
    logic [SCALE_W-1:0]        scale_reg;
    logic [RET_W-1:0]          ret_reg;
    logic [CH_W-1:0]           charge_reg, charge_next;
    logic signed [CUR_W-1:0]   last_reg;

    // working registers
    logic                      neg_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic signed [P_W-1:0]     prod_reg, lo_reg;
    logic [NC_W-2:0]           nc_reg;
    logic [X_W-1:0]            x_reg;
    logic                      dep_reg;
    logic signed [ACC_W-1:0]   v_reg, r_reg;

    // output words
    logic [X_W-1:0]            charge_level_reg;
    logic [VOLT_W-1:0]         open_voltage_reg;
    logic [RES_W-1:0]          series_resistance_reg;
    logic                      depleted_reg;

    logic signed [SUM_W-1:0]   sum_w;
    logic [MAG_W-1:0]          mag_w;
    logic signed [A_W-1:0]     mul_a;
    logic signed [B_W-1:0]     mul_b;
    logic [DSUM_W-1:0]         dsum;
    logic [DELTA_W-1:0]        delta;
    logic signed [NC_W-1:0]    nc_s;
    logic [NC_W-2:0]           nc_w;
    logic [RSUM_W-1:0]         rsum;
    logic [NC_W-2:0]           c_w;
    logic [X_W-1:0]            x_calc;
    logic                      dep_calc;
    logic signed [P_W-1:0]     pr_adj;
    logic signed [P_W-1:0]     pr_rnd;
    logic signed [ACC_W-1:0]   acc_new;
    logic signed [ACC_W-1:0]   vq;
    logic [VOLT_W-1:0]         volt_sat;
    logic [RES_W-1:0]          res_sat;

    // trapezoid sum and its magnitude
    always_comb
    begin
        sum_w = SUM_W'(current_sample) + SUM_W'(last_reg);
        mag_w = sum_w[SUM_W-1] ? MAG_W'(-sum_w) : MAG_W'(sum_w);
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MS_SCALE_LO:
            begin
                mul_a = $signed(A_W'(mag_reg));
                mul_b = $signed(B_W'(scale_reg[SCALE_HALF-1:0]));
            end
            MS_SCALE_HI:
            begin
                mul_a = $signed(A_W'(mag_reg));
                mul_b = $signed(B_W'(scale_reg[SCALE_W-1:SCALE_HALF]));
            end
            MS_RET_LO:
            begin
                mul_a = $signed(A_W'(nc_reg));
                mul_b = $signed(B_W'(ret_reg[RET_HALF-1:0]));
            end
            MS_RET_HI:
            begin
                mul_a = $signed(A_W'(nc_reg));
                mul_b = $signed(B_W'(ret_reg[RET_W-1:RET_HALF]));
            end
            MS_POLY:
            begin
                mul_a = (cmd.step < STEP_W'(VOLT_STEPS)) ? A_W'(v_reg) : A_W'(r_reg);
                mul_b = $signed(B_W'(x_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // charge step, rounded half away from zero, then subtracted (added when charging)
    always_comb
    begin
        dsum  = (DSUM_W'(prod_reg[DPR_W-1:0]) << SCALE_HALF)
              + DSUM_W'(lo_reg[DPR_W-1:0]) + (DSUM_W'(1) << 31);
        delta = dsum[32 +: DELTA_W];
        nc_s  = $signed(NC_W'(charge_reg))
              + (neg_reg ? $signed(NC_W'(delta)) : -$signed(NC_W'(delta)));
        nc_w  = (nc_s <= 0) ? '0 : nc_s[NC_W-2:0];
    end

    // retain multiply, rounded half up, clamped at full
    always_comb
    begin
        rsum = (RSUM_W'(prod_reg[RPR_W-1:0]) << RET_HALF)
             + RSUM_W'(lo_reg[RPR_W-1:0]) + (RSUM_W'(1) << 31);
        c_w  = rsum[32 +: NC_W-1];
        charge_next = (c_w > (NC_W-1)'(FULL)) ? FULL : c_w[CH_W-1:0];
    end

    // rescale the charge to q24
    generate
        if (FRAC_BITS >= X_FRAC)
        begin : g_narrow
            localparam int SH = FRAC_BITS - X_FRAC;
            logic [CH_W:0] sum_r;
            assign sum_r  = {1'b0, charge_reg} + (((CH_W+1)'(1) << SH) >> 1);
            assign x_calc = X_W'(sum_r >> SH);
        end
        else
        begin : g_widen
            assign x_calc = X_W'({charge_reg, {(X_FRAC-FRAC_BITS){1'b0}}});
        end
    endgenerate

    assign dep_calc = (DEP_W'(charge_reg) * DEP_W'(100)) <= DEP_W'(FULL);

    // horner step: product over 2^24 rounded half away from zero, plus coefficient
    always_comb
    begin
        pr_adj  = prod_reg + (prod_reg[P_W-1] ? $signed(P_W'((1 << (X_FRAC-1)) - 1))
                                              : $signed(P_W'(1 << (X_FRAC-1))));
        pr_rnd  = pr_adj >>> X_FRAC;
        acc_new = $signed(pr_rnd[ACC_W-1:0]) + poly_coef(cmd.step);
    end

    // final voltage q24 to q16 and saturation of both fits
    always_comb
    begin
        vq = (v_reg + (v_reg[ACC_W-1] ? $signed(ACC_W'((1 << (VQ_SH-1)) - 1))
                                      : $signed(ACC_W'(1 << (VQ_SH-1))))) >>> VQ_SH;
        if (vq < 0)
        begin
            volt_sat = '0;
        end
        else if (vq > VOLT_SAT)
        begin
            volt_sat = VOLT_SAT[VOLT_W-1:0];
        end
        else
        begin
            volt_sat = vq[VOLT_W-1:0];
        end
        if (r_reg < 0)
        begin
            res_sat = '0;
        end
        else if (r_reg > RES_SAT)
        begin
            res_sat = RES_SAT[RES_W-1:0];
        end
        else
        begin
            res_sat = r_reg[RES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RST;
            ret_reg    <= RETAIN_RST;
            charge_reg <= FULL;
            last_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHARGE_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                    CFG_RETAIN:       ret_reg   <= cfg_data[RET_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.load_in)
            begin
                last_reg <= current_sample;
            end
            if (cmd.charge_en)
            begin
                charge_reg <= charge_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            neg_reg <= sum_w[SUM_W-1];
            mag_reg <= mag_w;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.save_lo)
        begin
            lo_reg <= prod_reg;
        end
        if (cmd.delta_en)
        begin
            nc_reg <= nc_w;
        end
        if (cmd.x_en)
        begin
            x_reg   <= x_calc;
            dep_reg <= dep_calc;
        end
        if (cmd.poly_init)
        begin
            v_reg <= VOC_P1;
            r_reg <= -RS_P1;
        end
        else if (cmd.poly_add)
        begin
            if (cmd.step < STEP_W'(VOLT_STEPS))
            begin
                v_reg <= acc_new;
            end
            else
            begin
                r_reg <= acc_new;
            end
        end
        if (cmd.out_load)
        begin
            charge_level_reg      <= x_reg;
            open_voltage_reg      <= volt_sat;
            series_resistance_reg <= res_sat;
            depleted_reg          <= dep_reg;
        end
    end

    assign charge_level      = charge_level_reg;
    assign open_voltage      = open_voltage_reg;
    assign series_resistance = series_resistance_reg;
    assign depleted          = depleted_reg;

    // stored charge never goes above full
    a_charge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        charge_reg <= FULL)
        else $error("stored charge above full");

    // charge only moves on the retain step
    a_charge_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.charge_en) |-> $stable(charge_reg))
        else $error("stored charge changed outside its update");

    // previous sample only moves when a word is taken
    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.load_in) |-> $stable(last_reg))
        else $error("previous sample changed without an accepted word");

endmodule
